/* sv/stun_reflexive_address_tracker_assert.svh */
// Assertion macros for the STUN reflexive address tracker.
`ifndef STUN_REFLEXIVE_ADDRESS_TRACKER_ASSERT_SVH
`define STUN_REFLEXIVE_ADDRESS_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SRAT_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// Next-cycle implication, checked outside of reset.
`define SRAT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

/* sv/srat_pkg.sv */
// Package with the types and constants of the STUN reflexive address tracker.
package srat_pkg;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned CNT_W   = 9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 9'd511;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef enum logic [0:0] {
        CMD_TICK     = 1'b0,
        CMD_RESPONSE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_SUCCESS    = 2'd0,
        CLS_ERROR      = 2'd1,
        CLS_REQUEST    = 2'd2,
        CLS_INDICATION = 2'd3
    } rclass_t;

    typedef enum logic [1:0] {
        CHG_NONE   = 2'd0,
        CHG_SET    = 2'd1,
        CHG_UNSET  = 2'd2,
        CHG_CHANGE = 2'd3
    } chg_t;

    typedef enum logic [0:0] {
        MODE_REQUEST    = 1'b0,
        MODE_INDICATION = 1'b1
    } mode_t;

endpackage

/* sv/stun_reflexive_address_tracker.sv */
// Top level of the STUN reflexive address tracker: state, input and result registers.
//
// The tracker follows one STUN server and the server-reflexive address it
// reports. Each input item is either a send tick, which carries the configured
// server address and may start, stop or switch the server or continue the
// keepalive schedule, or a received response, which may set or change the
// learned address. Every item gives exactly one result item that tells whether
// a binding message goes out, of which class, and whether the learned address
// was set, unset or changed, along with the learned address and the server whose
// address was last dropped. The block takes one item per clock cycle without
// gaps while the result side is not held back by m_ready. An accepted item is
// held in the input register and then moves to the result register; the single
// update of the tracker state lies between those two registers. The input
// side keeps accepting while a result waits to be taken, as long as the input
// register is free or moves on in the same cycle. The indication_limit
// register is written through the cfg port, which is always ready, and must
// only be written while no item is in flight. There is no clearing pass after
// reset.
module stun_reflexive_address_tracker (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [srat_pkg::LIMIT_W-1:0] cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [srat_pkg::ADDR_W-1:0] s_server_address,
    input  logic [1:0]                  s_response_class,
    input  logic                        s_unknown_required_attr,
    input  logic                        s_has_mapped_address,
    input  logic [srat_pkg::ADDR_W-1:0] s_mapped_address,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_address_change,
    output logic                        m_send_message,
    output logic                        m_message_kind,
    output logic [srat_pkg::ADDR_W-1:0] m_learned_address,
    output logic [srat_pkg::ADDR_W-1:0] m_dropped_server
);

    // Configuration register.
    srat_pkg::limit_t limit_reg;

    // Tracker state.
    srat_pkg::addr_t  cur_server_reg, cur_server_next;
    srat_pkg::addr_t  refl_addr_reg,  refl_addr_next;
    srat_pkg::mode_t  mode_reg,       mode_next;
    srat_pkg::cnt_t   cnt_reg,        cnt_next;
    srat_pkg::addr_t  unset_srv_reg,  unset_srv_next;

    // Input register.
    logic             in_vld_reg;
    srat_pkg::cmd_t   cmd_reg;
    srat_pkg::addr_t  srv_reg;
    srat_pkg::rclass_t rcls_reg;
    logic             unk_reg;
    logic             has_map_reg;
    srat_pkg::addr_t  map_reg;

    // Result register.
    logic             out_vld_reg;
    srat_pkg::chg_t   chg_reg,  chg_next;
    logic             sent_reg, sent_next;
    srat_pkg::mode_t  kind_reg, kind_next;
    srat_pkg::addr_t  learned_reg;
    srat_pkg::addr_t  dropped_reg;

    // The result register can take a new item when it is empty or being drained.
    logic advance;
    logic in_take;
    logic step;

    assign advance   = !out_vld_reg || m_ready;
    assign step      = in_vld_reg && advance;
    assign s_ready   = !in_vld_reg || advance;
    assign in_take   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Keepalive schedule terms for a tick to the tracked server.
    logic             sched_unset;
    srat_pkg::addr_t  sched_refl;
    logic             sched_restart;
    srat_pkg::mode_t  sched_mode;
    srat_pkg::cnt_t   sched_cnt;
    logic             resp_valid;

    always_comb begin
        // A request left unanswered for a full round drops the learned address.
        sched_unset   = (mode_reg == srat_pkg::MODE_REQUEST) && (refl_addr_reg != '0) &&
                        (cnt_reg == {1'b0, limit_reg});
        sched_refl    = sched_unset ? '0 : refl_addr_reg;
        // Fall back to a request when nothing is learned or the indication run is over.
        sched_restart = (sched_refl == '0) ||
                        ((mode_reg == srat_pkg::MODE_INDICATION) &&
                         (cnt_reg >= ({1'b0, limit_reg} + srat_pkg::cnt_t'(1))));
        sched_mode    = sched_restart ? srat_pkg::MODE_REQUEST : mode_reg;
        sched_cnt     = sched_restart ? '0 : cnt_reg;
        if (sched_cnt < srat_pkg::CNT_MAX) begin
            sched_cnt = sched_cnt + srat_pkg::cnt_t'(1);
        end

        resp_valid = (rcls_reg == srat_pkg::CLS_SUCCESS) && !unk_reg && has_map_reg &&
                     (map_reg != '0);
    end

    always_comb begin
        cur_server_next = cur_server_reg;
        refl_addr_next  = refl_addr_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        unset_srv_next  = unset_srv_reg;
        chg_next        = srat_pkg::CHG_NONE;
        sent_next       = 1'b0;
        kind_next       = srat_pkg::MODE_REQUEST;

        if (cmd_reg == srat_pkg::CMD_TICK) begin
            if (cur_server_reg == '0) begin
                if (srv_reg != '0) begin
                    // Start tracking: the first message is always a request.
                    cur_server_next = srv_reg;
                    refl_addr_next  = '0;
                    mode_next       = srat_pkg::MODE_REQUEST;
                    cnt_next        = srat_pkg::cnt_t'(1);
                    sent_next       = 1'b1;
                end
            end else if (srv_reg == '0) begin
                // Stop tracking; the mode is left as it was.
                chg_next        = (refl_addr_reg != '0) ? srat_pkg::CHG_UNSET
                                                        : srat_pkg::CHG_NONE;
                unset_srv_next  = cur_server_reg;
                cur_server_next = '0;
                refl_addr_next  = '0;
                cnt_next        = '0;
            end else if (srv_reg != cur_server_reg) begin
                // Switch servers: report the stop, then send a request to the new one.
                chg_next        = (refl_addr_reg != '0) ? srat_pkg::CHG_UNSET
                                                        : srat_pkg::CHG_NONE;
                unset_srv_next  = cur_server_reg;
                cur_server_next = srv_reg;
                refl_addr_next  = '0;
                mode_next       = srat_pkg::MODE_REQUEST;
                cnt_next        = srat_pkg::cnt_t'(1);
                sent_next       = 1'b1;
            end else begin
                chg_next       = sched_unset ? srat_pkg::CHG_UNSET : srat_pkg::CHG_NONE;
                unset_srv_next = sched_unset ? cur_server_reg : unset_srv_reg;
                refl_addr_next = sched_refl;
                mode_next      = sched_mode;
                cnt_next       = sched_cnt;
                sent_next      = 1'b1;
                kind_next      = sched_mode;
            end
        end else if (resp_valid) begin
            // A good success response switches to indications even with no server.
            mode_next = srat_pkg::MODE_INDICATION;
            if (map_reg != refl_addr_reg) begin
                chg_next       = (refl_addr_reg == '0) ? srat_pkg::CHG_SET
                                                       : srat_pkg::CHG_CHANGE;
                refl_addr_next = map_reg;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= srat_pkg::LIMIT_RESET;
            cur_server_reg <= '0;
            refl_addr_reg  <= '0;
            mode_reg       <= srat_pkg::MODE_REQUEST;
            cnt_reg        <= '0;
            unset_srv_reg  <= '0;
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (step) begin
                cur_server_reg <= cur_server_next;
                refl_addr_reg  <= refl_addr_next;
                mode_reg       <= mode_next;
                cnt_reg        <= cnt_next;
                unset_srv_reg  <= unset_srv_next;
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg     <= srat_pkg::cmd_t'(s_command);
            srv_reg     <= s_server_address;
            rcls_reg    <= srat_pkg::rclass_t'(s_response_class);
            unk_reg     <= s_unknown_required_attr;
            has_map_reg <= s_has_mapped_address;
            map_reg     <= s_mapped_address;
        end
        if (step) begin
            chg_reg     <= chg_next;
            sent_reg    <= sent_next;
            kind_reg    <= kind_next;
            learned_reg <= refl_addr_next;
            dropped_reg <= unset_srv_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_address_change  = chg_reg;
    assign m_send_message    = sent_reg;
    assign m_message_kind    = kind_reg;
    assign m_learned_address = learned_reg;
    assign m_dropped_server  = dropped_reg;

`include "stun_reflexive_address_tracker_assert.svh"

    // An indication is only reported with a message that actually goes out.
    `SRAT_ASSERT_NOW(a_kind_needs_send, aclk, aresetn,
        out_vld_reg && (kind_reg == srat_pkg::MODE_INDICATION), sent_reg)

    // An unset always leaves no learned address behind.
    `SRAT_ASSERT_NOW(a_unset_clears, aclk, aresetn,
        out_vld_reg && (chg_reg == srat_pkg::CHG_UNSET), learned_reg == '0)

    // A full pipeline that is stalled at the output must not take a new item.
    `SRAT_ASSERT_NOW(a_no_overrun, aclk, aresetn,
        in_vld_reg && out_vld_reg && !m_ready, !s_ready)

    // A set or change always brings a nonzero learned address.
    `SRAT_ASSERT_NEXT(a_set_nonzero, aclk, aresetn,
        step && ((chg_next == srat_pkg::CHG_SET) || (chg_next == srat_pkg::CHG_CHANGE)),
        learned_reg != '0)

endmodule
